// ===== src/utd_pkg.sv =====
// Shared types and byte constants for the UTF-8 to 16-bit code decoder.
package utd_pkg;

    // Byte classification constants
    localparam logic [7:0] ASCII_LIMIT = 8'h80;
    localparam logic [7:0] LEAD3_START = 8'hE0;
    localparam logic [7:0] LEAD4_START = 8'hF0;
    localparam logic [7:0] BAD_START   = 8'hF8;
    localparam logic [7:0] CONT_MASK   = 8'hC0;
    localparam logic [7:0] CONT_TAG    = 8'h80;

    // Payload masks for each lead kind and for continuations
    localparam logic [7:0] LEAD2_MASK  = 8'h1F;
    localparam logic [7:0] LEAD3_MASK  = 8'h0F;
    localparam logic [7:0] LEAD4_MASK  = 8'h07;
    localparam logic [7:0] CONT_BITS   = 8'h3F;

    // Continuations still expected after each lead kind
    localparam logic [1:0] REM_NONE  = 2'd0;
    localparam logic [1:0] REM_ONE   = 2'd1;
    localparam logic [1:0] REM_TWO   = 2'd2;
    localparam logic [1:0] REM_THREE = 2'd3;

    localparam int CODE_W = 16;

    // One decoded result word
    typedef struct packed {
        logic [CODE_W-1:0] code_unit;
        logic              is_multibyte;
        logic              last_of_run;
    } result_t;

    // Results caused by one input byte (zero, one or two)
    typedef struct packed {
        logic [1:0] count;
        result_t    res_a;
        result_t    res_b;
    } dec_out_t;

endpackage

// ===== src/utd_decoder.sv =====
// Sequence state and per-byte decode logic.
module utd_decoder
    import utd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     take,
    input  logic [7:0] in_byte,
    output dec_out_t dec
);

    logic [CODE_W-1:0] acc_reg, acc_next;
    logic [1:0]        rem_reg, rem_next;

    logic [CODE_W-1:0] acc_cont;
    logic [CODE_W-1:0] lead_code;
    logic              lead_emit;
    logic              lead_multi;
    logic              is_cont;

    // Classify the byte and work out results and next state
    always_comb
    begin
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        dec        = '0;
        acc_cont   = {acc_reg[CODE_W-7:0], in_byte[5:0] & CONT_BITS[5:0]};
        is_cont    = (in_byte & CONT_MASK) == CONT_TAG;
        lead_code  = '0;
        lead_emit  = 1'b0;
        lead_multi = 1'b0;

        if (rem_reg != REM_NONE && is_cont)
        begin
            // Shift six payload bits in; close on the last continuation
            acc_next = acc_cont;
            rem_next = rem_reg - 2'd1;
            if (rem_reg == REM_ONE)
            begin
                dec.count = 2'd1;
                dec.res_a = '{code_unit: acc_cont, is_multibyte: 1'b1, last_of_run: 1'b0};
            end
        end
        else
        begin
            // Flush a cut-short sequence before the new lead
            if (rem_reg != REM_NONE)
            begin
                dec.count = 2'd1;
                dec.res_a = '{code_unit: acc_reg, is_multibyte: 1'b1, last_of_run: 1'b0};
                rem_next  = REM_NONE;
            end

            // Decode the byte as a lead
            if (in_byte < ASCII_LIMIT)
            begin
                lead_emit = 1'b1;
                lead_code = {{(CODE_W-8){1'b0}}, in_byte};
            end
            else if (in_byte < LEAD3_START)
            begin
                acc_next = {{(CODE_W-8){1'b0}}, in_byte & LEAD2_MASK};
                rem_next = REM_ONE;
            end
            else if (in_byte < LEAD4_START)
            begin
                acc_next = {{(CODE_W-8){1'b0}}, in_byte & LEAD3_MASK};
                rem_next = REM_TWO;
            end
            else if (in_byte < BAD_START)
            begin
                acc_next = {{(CODE_W-8){1'b0}}, in_byte & LEAD4_MASK};
                rem_next = REM_THREE;
            end
            else
            begin
                lead_emit  = 1'b1;
                lead_multi = 1'b1;
            end

            if (lead_emit)
            begin
                if (dec.count == 2'd1)
                begin
                    dec.count = 2'd2;
                    dec.res_b = '{code_unit: lead_code, is_multibyte: lead_multi,
                                  last_of_run: 1'b0};
                end
                else
                begin
                    dec.count = 2'd1;
                    dec.res_a = '{code_unit: lead_code, is_multibyte: lead_multi,
                                  last_of_run: 1'b0};
                end
            end
        end

        // Mark the final result of this byte
        if (dec.count == 2'd1)
            dec.res_a.last_of_run = 1'b1;
        else if (dec.count == 2'd2)
            dec.res_b.last_of_run = 1'b1;
    end

    // Hold sequence state; advance on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            rem_reg <= REM_NONE;
        end
        else if (take)
        begin
            acc_reg <= acc_next;
            rem_reg <= rem_next;
        end
    end

endmodule

// ===== src/utd_result_queue.sv =====
// Small result queue: takes up to two words per cycle, hands out one per cycle while out_ready is high.
module utd_result_queue
    import utd_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  dec_out_t push_data,
    output logic     has_room,
    output logic     out_valid,
    input  logic     out_ready,
    output result_t  out_word
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

    result_t       mem_reg [DEPTH];
    logic [PW-1:0] wr_reg, wr_next, wr_plus1, wr_plus2;
    logic [PW-1:0] rd_reg, rd_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [1:0]    n_push;
    logic          pop;

    assign n_push   = push ? push_data.count : 2'd0;
    assign pop      = out_valid && out_ready;
    assign wr_plus1 = (wr_reg == LAST_SLOT) ? '0 : wr_reg + PW'(1);
    assign wr_plus2 = (wr_plus1 == LAST_SLOT) ? '0 : wr_plus1 + PW'(1);

    // Advance pointers and the fill count
    always_comb
    begin
        case (n_push)
            2'd1:    wr_next = wr_plus1;
            2'd2:    wr_next = wr_plus2;
            default: wr_next = wr_reg;
        endcase
        rd_next  = pop ? ((rd_reg == LAST_SLOT) ? '0 : rd_reg + PW'(1)) : rd_reg;
        cnt_next = cnt_reg + CW'(n_push) - CW'(pop);
    end

    assign has_room  = cnt_reg <= CW'(DEPTH - 2);
    assign out_valid = cnt_reg != '0;
    assign out_word  = mem_reg[rd_reg];

    // Store pushed words
    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
            mem_reg[wr_reg] <= push_data.res_a;
        if (n_push == 2'd2)
            mem_reg[wr_plus1] <= push_data.res_b;
    end

    // Hold pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== src/utf8_to_utf16_stream_decoder_core.sv =====
// UTF-8 byte stream to 16-bit code stream decoder, top level.
// Takes one UTF-8 byte per word on the s_ side and gives decoded 16-bit codes
// on the m_ side. The decode of a byte is a compare, mask and six-bit shift on
// the sequence state, and its results are written straight into a result
// queue of QUEUE_DEPTH words, so bytes stream in at one per cycle while the
// queue has room for two words. A byte that closes a cut-short sequence and
// is itself ASCII or invalid gives two words, which leave one at a time; the
// output port's one word per cycle while m_tready is high is then the
// limit. m_tuser is 1 for codes from multibyte, cut-short or invalid input,
// and m_tlast marks the last word caused by one input byte. Codes are kept to
// their low 16 bits and overlong forms are passed without checks.
module utf8_to_utf16_stream_decoder_core
    import utd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4   // result words buffered, 3 or more
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] in_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [15:0] code_unit
    output logic        m_tuser,    // [0] is_multibyte
    output logic        m_tlast     // last_of_run
);

    dec_out_t dec;
    result_t  out_word;
    logic     take;
    logic     has_room;

    assign s_tready = has_room;
    assign take     = s_tvalid && has_room;

    // Decode the incoming byte against the open sequence
    utd_decoder u_decoder (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .in_byte (s_tdata),
        .dec     (dec)
    );

    // Buffer results for the output side
    utd_result_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (take),
        .push_data (dec),
        .has_room  (has_room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (out_word)
    );

    assign m_tdata = out_word.code_unit;
    assign m_tuser = out_word.is_multibyte;
    assign m_tlast = out_word.last_of_run;

endmodule

// ===== src/utd_checker.sv =====
// Port-level checks for the decoder top level, bound in below.
module utd_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // No output word once reset has been seen at an edge
    assert property (@(posedge clk) !rst_n |=> !m_tvalid)
        else $error("output valid during reset");

    // Hold a stalled output word
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
            && $stable(m_tuser) && $stable(m_tlast))
        else $error("stalled output word changed");

    // An ASCII word is a single byte and always ends its run
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[15:7] == 9'd0 && m_tlast)
        else $error("ASCII word out of range or not last");

    // The first of two words from one byte is always a flushed sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> m_tuser)
        else $error("non-final word not marked multibyte");

endmodule

bind utf8_to_utf16_stream_decoder_core utd_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
